/* hdl/ramst_pkg.sv */
// Shared types, command/status structs and saturating arithmetic for the
// range-add / global-minimum segment tree. No dependencies.
`default_nettype none
package ramst_pkg;

    localparam int MAX_SIZE_DEF = 1024;
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 11;
    localparam int POS_W        = 11;
    localparam int IDX_W        = 10;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_BLD_LEAF,
        OP_BLD_NODE,
        OP_P0,
        OP_P1,
        OP_P2,
        OP_P3,
        OP_P4,
        OP_A0,
        OP_A1,
        OP_L0,
        OP_L1,
        OP_L2,
        OP_RD0,
        OP_RD1,
        OP_RT0,
        OP_RT1
    } t_op;

    // Frame stack operations
    typedef enum logic [2:0] {
        STK_NONE,
        STK_PUSH_L,
        STK_PUSH_R,
        STK_POP,
        STK_TAIL
    } t_stk;

    typedef struct packed {
        t_op  op;
        t_stk stk;
    } t_cmd;

    typedef struct packed {
        logic leaf;
        logic disjoint;
        logic covered;
        logic dep_zero;
        logic top_ph2;
        logic pend_zero;
        logic req_err;
        logic req_empty;
    } t_sts;

    // Add two signed words, sticking at the extremes
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        logic signed [DATA_W-1:0] res;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            res = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = s[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* hdl/ramst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ramst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then read with registered output held between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* hdl/ramst_dp.sv */
// Datapath: node memories, frame stack, request and result registers.
// Depends on ramst_pkg and ramst_ram; driven by ramst_ctrl commands.
`default_nettype none
module ramst_dp #(
    parameter int MAX_SIZE = ramst_pkg::MAX_SIZE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ramst_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                              i_req_type,
    input  wire logic [ramst_pkg::POS_W-1:0]       i_range_low,
    input  wire logic [ramst_pkg::POS_W-1:0]       i_range_high,
    input  wire logic signed [ramst_pkg::DATA_W-1:0] i_delta,
    input  wire logic [ramst_pkg::IDX_W-1:0]       i_point_index,
    input  wire ramst_pkg::t_cmd                   i_cmd,
    output ramst_pkg::t_sts                        o_sts,
    output logic signed [ramst_pkg::DATA_W-1:0]    o_point_value,
    output logic signed [ramst_pkg::DATA_W-1:0]    o_min_value,
    output logic [ramst_pkg::IDX_W-1:0]            o_min_index,
    output logic                                   o_index_error
);
    import ramst_pkg::*;

    localparam int NODES = 4 * MAX_SIZE;
    localparam int KW    = $clog2(NODES);
    localparam int SZW   = $clog2(MAX_SIZE + 1);
    localparam int SLW   = $clog2(MAX_SIZE);
    localparam int CW    = (SZW > CFG_W) ? SZW : CFG_W;
    localparam int SD    = $clog2(MAX_SIZE) + 1;
    localparam int SDW   = $clog2(SD);
    localparam int VSW   = DATA_W + SLW;

    // Size and frame stack
    logic [SZW-1:0] r_size;
    logic [KW-1:0]  r_top_k;
    logic [SZW-1:0] r_top_lo, r_top_hi;
    logic           r_top_ph;
    logic [SDW-1:0] r_dep;
    logic [KW-1:0]  r_stk_k  [SD];
    logic [SZW-1:0] r_stk_lo [SD];
    logic [SZW-1:0] r_stk_hi [SD];
    logic           r_stk_ph [SD];

    // Request and scratch registers
    logic [POS_W-1:0]         r_l, r_r;
    logic signed [DATA_W-1:0] r_d;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_err;
    logic signed [DATA_W-1:0] r_pv;
    logic signed [DATA_W-1:0] r_p;
    logic [VSW-1:0]           r_va, r_vb;

    // Memory ports
    logic           vs_we, vs_re, pd_we, pd_re;
    logic [KW-1:0]  vs_waddr, vs_raddr, pd_waddr, pd_raddr;
    logic [VSW-1:0] vs_wdata, vs_q;
    logic [DATA_W-1:0] pd_wdata, pd_q;

    logic [SZW:0]   mid_sum;
    logic [SZW-1:0] mid;
    logic [KW-1:0]  k_a, k_b;
    logic [SZW-1:0] cfg_size;
    logic signed [DATA_W-1:0] vq_val, va_val;
    logic           pick_a;

    ramst_ram #(.WIDTH(VSW), .DEPTH(NODES)) u_vs (
        .i_clk(i_clk), .i_we(vs_we), .i_waddr(vs_waddr), .i_wdata(vs_wdata),
        .i_re(vs_re), .i_raddr(vs_raddr), .o_rdata(vs_q)
    );

    ramst_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_pd (
        .i_clk(i_clk), .i_we(pd_we), .i_waddr(pd_waddr), .i_wdata(pd_wdata),
        .i_re(pd_re), .i_raddr(pd_raddr), .o_rdata(pd_q)
    );

    // Split point and child addresses of the current frame
    assign mid_sum = {1'b0, r_top_lo} + {1'b0, r_top_hi};
    assign mid     = mid_sum[SZW:1];
    assign k_a     = KW'({r_top_k, 1'b1});
    assign k_b     = k_a + 1'b1;

    // Clamp a written size into [1, MAX_SIZE]
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_size = SZW'(1);
        end else if (CW'(i_cfg_wdata) > CW'(MAX_SIZE)) begin
            cfg_size = SZW'(MAX_SIZE);
        end else begin
            cfg_size = SZW'(i_cfg_wdata);
        end
    end

    // Status for the controller
    always_comb begin
        o_sts.leaf      = ({1'b0, r_top_hi} == ({1'b0, r_top_lo} + 1'b1));
        o_sts.disjoint  = (CW'(r_l) >= CW'(r_top_hi)) || (CW'(r_top_lo) >= CW'(r_r));
        o_sts.covered   = (CW'(r_top_lo) >= CW'(r_l)) && (CW'(r_top_hi) <= CW'(r_r));
        o_sts.dep_zero  = (r_dep == '0);
        o_sts.top_ph2   = r_top_ph;
        o_sts.pend_zero = (pd_q == '0);
        o_sts.req_err   = i_req_type && (CW'(i_point_index) >= CW'(r_size));
        o_sts.req_empty = !i_req_type && (i_range_high <= i_range_low);
    end

    assign vq_val = vs_q[VSW-1:SLW];
    assign va_val = r_va[VSW-1:SLW];
    assign pick_a = (va_val < vq_val) ||
                    ((va_val == vq_val) && (r_va[SLW-1:0] < vs_q[SLW-1:0]));

    // Memory control per micro-operation
    always_comb begin
        vs_we = 1'b0; vs_re = 1'b0; pd_we = 1'b0; pd_re = 1'b0;
        vs_waddr = r_top_k; vs_raddr = r_top_k;
        pd_waddr = r_top_k; pd_raddr = r_top_k;
        vs_wdata = '0; pd_wdata = '0;
        unique case (i_cmd.op)
            OP_BLD_LEAF: begin
                vs_we    = 1'b1;
                vs_wdata = {DATA_W'(r_top_lo) + DATA_W'(1), SLW'(r_top_lo)};
                pd_we    = 1'b1;
            end
            OP_BLD_NODE: begin
                pd_we = 1'b1;
            end
            OP_P0: begin
                pd_re = 1'b1;
                vs_re = 1'b1; vs_raddr = k_a;
            end
            OP_P1: begin
                pd_re = 1'b1; pd_raddr = k_a;
                vs_re = 1'b1; vs_raddr = k_b;
            end
            OP_P2: begin
                vs_we = 1'b1; vs_waddr = k_a;
                vs_wdata = {sat_add(va_val, r_p), r_va[SLW-1:0]};
                pd_we = 1'b1; pd_waddr = k_a; pd_wdata = sat_add(pd_q, r_p);
                pd_re = 1'b1; pd_raddr = k_b;
            end
            OP_P3: begin
                vs_we = 1'b1; vs_waddr = k_b;
                vs_wdata = {sat_add(r_vb[VSW-1:SLW], r_p), r_vb[SLW-1:0]};
                pd_we = 1'b1; pd_waddr = k_b; pd_wdata = sat_add(pd_q, r_p);
            end
            OP_P4: begin
                pd_we = 1'b1;
            end
            OP_A0: begin
                pd_re = 1'b1;
                vs_re = 1'b1;
            end
            OP_A1: begin
                pd_we = 1'b1; pd_wdata = sat_add(pd_q, r_d);
                vs_we = 1'b1; vs_wdata = {sat_add(vq_val, r_d), vs_q[SLW-1:0]};
            end
            OP_L0: begin
                vs_re = 1'b1; vs_raddr = k_a;
            end
            OP_L1: begin
                vs_re = 1'b1; vs_raddr = k_b;
            end
            OP_L2: begin
                vs_we = 1'b1; vs_wdata = pick_a ? r_va : vs_q;
            end
            OP_RD0: begin
                vs_re = 1'b1;
            end
            OP_RT0: begin
                vs_re = 1'b1; vs_raddr = '0;
            end
            default: begin
            end
        endcase
    end

    // Scratch, request and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_l   <= i_range_low;
                r_r   <= i_range_high;
                r_d   <= i_delta;
                r_idx <= i_point_index;
                r_err <= o_sts.req_err;
                r_pv  <= '0;
            end
            OP_P1: begin
                r_p  <= pd_q;
                r_va <= vs_q;
            end
            OP_P2: r_vb <= vs_q;
            OP_L1: r_va <= vs_q;
            OP_RD1: r_pv <= vq_val;
            OP_RT1: begin
                o_point_value <= r_pv;
                o_min_value   <= vq_val;
                o_min_index   <= IDX_W'(vs_q[SLW-1:0]);
                o_index_error <= r_err;
            end
            default: begin
            end
        endcase
    end

    // Frame stack and active size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SZW'(MAX_SIZE);
            r_top_k  <= '0;
            r_top_lo <= '0;
            r_top_hi <= SZW'(MAX_SIZE);
            r_top_ph <= 1'b0;
            r_dep    <= '0;
        end else if (i_cfg_we) begin
            r_size   <= cfg_size;
            r_top_k  <= '0;
            r_top_lo <= '0;
            r_top_hi <= cfg_size;
            r_dep    <= '0;
        end else if (i_cmd.op == OP_LATCH) begin
            r_top_k  <= '0;
            r_top_lo <= '0;
            r_top_hi <= r_size;
            r_dep    <= '0;
        end else begin
            unique case (i_cmd.stk)
                STK_PUSH_L, STK_PUSH_R: begin
                    r_stk_k[r_dep]  <= r_top_k;
                    r_stk_lo[r_dep] <= r_top_lo;
                    r_stk_hi[r_dep] <= r_top_hi;
                    r_stk_ph[r_dep] <= (i_cmd.stk == STK_PUSH_R);
                    r_dep           <= r_dep + 1'b1;
                    if (i_cmd.stk == STK_PUSH_L) begin
                        r_top_k  <= k_a;
                        r_top_hi <= mid;
                    end else begin
                        r_top_k  <= k_b;
                        r_top_lo <= mid;
                    end
                end
                STK_POP: begin
                    r_top_k  <= r_stk_k[r_dep - 1'b1];
                    r_top_lo <= r_stk_lo[r_dep - 1'b1];
                    r_top_hi <= r_stk_hi[r_dep - 1'b1];
                    r_top_ph <= r_stk_ph[r_dep - 1'b1];
                    r_dep    <= r_dep - 1'b1;
                end
                STK_TAIL: begin
                    if (CW'(r_idx) < CW'(mid)) begin
                        r_top_k  <= k_a;
                        r_top_hi <= mid;
                    end else begin
                        r_top_k  <= k_b;
                        r_top_lo <= mid;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/ramst_ctrl.sv */
// Controller: state machine that sequences tree walks, pushes, pulls and
// results. Depends on ramst_pkg; drives ramst_dp through t_cmd.
`default_nettype none
module ramst_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_in_valid,
    input  wire logic            i_req_type,
    input  wire logic            i_out_stall,
    input  wire ramst_pkg::t_sts i_sts,
    output ramst_pkg::t_cmd      o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);
    import ramst_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ENTER = 5'd1;
    localparam logic [4:0] S_P0    = 5'd2;
    localparam logic [4:0] S_P1    = 5'd3;
    localparam logic [4:0] S_P2    = 5'd4;
    localparam logic [4:0] S_P3    = 5'd5;
    localparam logic [4:0] S_P4    = 5'd6;
    localparam logic [4:0] S_A0    = 5'd7;
    localparam logic [4:0] S_A1    = 5'd8;
    localparam logic [4:0] S_L0    = 5'd9;
    localparam logic [4:0] S_L1    = 5'd10;
    localparam logic [4:0] S_L2    = 5'd11;
    localparam logic [4:0] S_RET   = 5'd12;
    localparam logic [4:0] S_R0    = 5'd13;
    localparam logic [4:0] S_R1    = 5'd14;
    localparam logic [4:0] S_T0    = 5'd15;
    localparam logic [4:0] S_T1    = 5'd16;

    localparam logic [1:0] M_BUILD = 2'd0;
    localparam logic [1:0] M_ADD   = 2'd1;
    localparam logic [1:0] M_READ  = 2'd2;

    logic [4:0] r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic       r_ovalid, n_ovalid;
    logic       in_acc, out_free;

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_we;
    assign o_out_valid = r_ovalid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_ovalid  = r_ovalid && i_out_stall;
        o_cmd.op  = OP_NONE;
        o_cmd.stk = STK_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.op = OP_LATCH;
                    n_mode   = i_req_type ? M_READ : M_ADD;
                    n_state  = (i_sts.req_err || i_sts.req_empty) ? S_T0 : S_ENTER;
                end
            end
            S_ENTER: begin
                if (r_mode == M_BUILD) begin
                    if (i_sts.leaf) begin
                        o_cmd.op = OP_BLD_LEAF;
                        if (i_sts.dep_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.stk = STK_POP;
                            n_state   = S_RET;
                        end
                    end else begin
                        o_cmd.op  = OP_BLD_NODE;
                        o_cmd.stk = STK_PUSH_L;
                    end
                end else if (r_mode == M_READ) begin
                    n_state = i_sts.leaf ? S_R0 : S_P0;
                end else if (i_sts.disjoint) begin
                    // finish this frame untouched
                    if (i_sts.dep_zero) begin
                        n_state = S_T0;
                    end else begin
                        o_cmd.stk = STK_POP;
                        n_state   = S_RET;
                    end
                end else begin
                    n_state = i_sts.leaf ? S_A0 : S_P0;
                end
            end
            S_P0: begin
                o_cmd.op = OP_P0;
                n_state  = S_P1;
            end
            S_P1: begin
                o_cmd.op = OP_P1;
                if (i_sts.pend_zero) begin
                    // nothing pending: skip the push
                    o_cmd.op = OP_NONE;
                    if (r_mode == M_READ) begin
                        o_cmd.stk = STK_TAIL;
                        n_state   = S_ENTER;
                    end else if (i_sts.covered) begin
                        n_state = S_A0;
                    end else begin
                        o_cmd.stk = STK_PUSH_L;
                        n_state   = S_ENTER;
                    end
                end else begin
                    n_state = S_P2;
                end
            end
            S_P2: begin
                o_cmd.op = OP_P2;
                n_state  = S_P3;
            end
            S_P3: begin
                o_cmd.op = OP_P3;
                n_state  = S_P4;
            end
            S_P4: begin
                o_cmd.op = OP_P4;
                if (r_mode == M_READ) begin
                    o_cmd.stk = STK_TAIL;
                    n_state   = S_ENTER;
                end else if (i_sts.covered) begin
                    n_state = S_A0;
                end else begin
                    o_cmd.stk = STK_PUSH_L;
                    n_state   = S_ENTER;
                end
            end
            S_A0: begin
                o_cmd.op = OP_A0;
                n_state  = S_A1;
            end
            S_A1, S_L2: begin
                o_cmd.op = (r_state == S_A1) ? OP_A1 : OP_L2;
                if (i_sts.dep_zero) begin
                    n_state = (r_mode == M_BUILD) ? S_IDLE : S_T0;
                end else begin
                    o_cmd.stk = STK_POP;
                    n_state   = S_RET;
                end
            end
            S_L0: begin
                o_cmd.op = OP_L0;
                n_state  = S_L1;
            end
            S_L1: begin
                o_cmd.op = OP_L1;
                n_state  = S_L2;
            end
            S_RET: begin
                // descend right after the left side, pull after the right
                if (i_sts.top_ph2) begin
                    n_state = S_L0;
                end else begin
                    o_cmd.stk = STK_PUSH_R;
                    n_state   = S_ENTER;
                end
            end
            S_R0: begin
                o_cmd.op = OP_RD0;
                n_state  = S_R1;
            end
            S_R1: begin
                o_cmd.op = OP_RD1;
                n_state  = S_T0;
            end
            S_T0: begin
                o_cmd.op = OP_RT0;
                n_state  = S_T1;
            end
            S_T1: begin
                if (out_free) begin
                    o_cmd.op = OP_RT1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a size write restarts the build
        if (i_cfg_we) begin
            n_state   = S_ENTER;
            n_mode    = M_BUILD;
            o_cmd.op  = OP_NONE;
            o_cmd.stk = STK_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ENTER;
            r_mode   <= M_BUILD;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_ovalid <= n_ovalid;
        end
    end
endmodule
`default_nettype wire

/* hdl/range_add_min_segment_tree.sv */
// Flow: accept latches the request; the result is read from the root (T0) and registered (T1).
// An add skips a disjoint node, adds to a covered one and descends into a split one, pushing
// pending values down (when any) and pulling the minimum up after. A read walks to its leaf; a bad
// read or an empty add goes straight to the result. Throughput: one item at a time, next item
// accepted after the result is registered. Reset and each size write rebuild the tree from the
// leaves up, input stalled meanwhile. Reset is synchronous.
`default_nettype none
module range_add_min_segment_tree #(
    parameter int MAX_SIZE = ramst_pkg::MAX_SIZE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ramst_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_req_type,
    input  wire logic [ramst_pkg::POS_W-1:0]         i_range_low,
    input  wire logic [ramst_pkg::POS_W-1:0]         i_range_high,
    input  wire logic signed [ramst_pkg::DATA_W-1:0] i_delta,
    input  wire logic [ramst_pkg::IDX_W-1:0]         i_point_index,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [ramst_pkg::DATA_W-1:0]      o_point_value,
    output logic signed [ramst_pkg::DATA_W-1:0]      o_min_value,
    output logic [ramst_pkg::IDX_W-1:0]              o_min_index,
    output logic                                     o_index_error
);
    import ramst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ramst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_in_valid(i_in_valid), .i_req_type(i_req_type),
        .i_out_stall(i_out_stall), .i_sts(sts), .o_cmd(cmd),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid)
    );

    ramst_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_req_type(i_req_type), .i_range_low(i_range_low),
        .i_range_high(i_range_high), .i_delta(i_delta),
        .i_point_index(i_point_index), .i_cmd(cmd), .o_sts(sts),
        .o_point_value(o_point_value), .o_min_value(o_min_value),
        .o_min_index(o_min_index), .o_index_error(o_index_error)
    );
endmodule
`default_nettype wire

/* hdl/ramst_chk.sv */
// Port-level checker for the segment tree top level, bound to it below.
// Depends on ramst_pkg for field widths.
`default_nettype none
module ramst_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_cfg_we,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_stall,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_stall,
    input wire logic signed [ramst_pkg::DATA_W-1:0] o_point_value,
    input wire logic signed [ramst_pkg::DATA_W-1:0] o_min_value,
    input wire logic [ramst_pkg::IDX_W-1:0]         o_min_index,
    input wire logic                                o_index_error
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_min_value)
            && $stable(o_min_index) && $stable(o_point_value)
            && $stable(o_index_error))
        else $error("stalled result changed");

    // Block input after an accepted item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while item in flight");

    // Block input while rebuilding after a size write
    a_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input open during rebuild");

    // Report zero value on a bad read
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> o_point_value == 0)
        else $error("bad read with nonzero value");
endmodule

bind range_add_min_segment_tree ramst_chk u_chk (.*);
`default_nettype wire
